@@ src/pmp_pkg.sv @@
`timescale 1ns / 1ps

package pmp_pkg;

	// Field widths
	localparam int POINT_W  = 24;
	localparam int PIX_W    = 16;
	localparam int FRAME_W  = 13;
	localparam int REG_W    = 64;
	localparam int LANE_W   = 16;
	localparam int ADDR_W   = 6;

	// Parameter defaults
	localparam int COORD_FRAC_BITS_DEF = 8;
	localparam int COEFF_BITS_DEF      = 16;

	// Datapath widths, sized for the full parameter ranges
	localparam int SUM_W = 42;
	localparam int NUM_W = SUM_W + 2;
	localparam int MAG_W = 42;
	localparam int QUO_W = 16;
	localparam int DIV_W = MAG_W + QUO_W;

	// Queue depths
	localparam int MIDQ_DEPTH = 8;
	localparam int OUTQ_DEPTH = 32;

	// Register indexes
	localparam logic [2:0] REG_ROW0   = 3'd0;
	localparam logic [2:0] REG_ROW1   = 3'd1;
	localparam logic [2:0] REG_ROW2   = 3'd2;
	localparam logic [2:0] REG_WIDTH  = 3'd3;
	localparam logic [2:0] REG_HEIGHT = 3'd4;

	// Reset camera
	localparam logic [REG_W-1:0] ROW0_RST = 64'hFE5C_0000_0190_FF42;
	localparam logic [REG_W-1:0] ROW1_RST = 64'h0460_FE70_0000_FF60;
	localparam logic [REG_W-1:0] ROW2_RST = 64'h0002_0000_0000_FFFF;
	localparam logic [FRAME_W-1:0] WIDTH_RST  = 13'd1500;
	localparam logic [FRAME_W-1:0] HEIGHT_RST = 13'd1000;

	// Classified item between front and back
	typedef struct packed {
		logic [MAG_W-1:0] mag_u;
		logic [MAG_W-1:0] mag_v;
		logic             neg_u;
		logic             neg_v;
		logic [MAG_W-1:0] den;
		logic             ok;
	} mid_t;

	// Finished result
	typedef struct packed {
		logic signed [PIX_W-1:0] col;
		logic signed [PIX_W-1:0] row;
		logic                    ok;
		logic                    in_frame;
	} res_t;

endpackage

@@ src/pmp_fifo.sv @@
`timescale 1ns / 1ps

module pmp_fifo #(
	parameter int W     = 8,
	parameter int DEPTH = 8
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         reserve,
	input  logic         push,
	input  logic [W-1:0] push_data,
	input  logic         pop,
	output logic         full,
	output logic         empty,
	output logic [W-1:0] pop_data
);

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);

	logic [W-1:0]     mem [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] fill_q;
	logic [CNT_W-1:0] credit_q;

	// Credits cover items in flight upstream plus stored entries
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			credit_q <= '0;
		end else if (reserve && !pop) begin
			credit_q <= credit_q + CNT_W'(1);
		end else if (!reserve && pop) begin
			credit_q <= credit_q - CNT_W'(1);
		end
	end

	// Advance pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			fill_q   <= '0;
		end else begin
			if (push) wr_ptr_q <= wr_ptr_q + PTR_W'(1);
			if (pop)  rd_ptr_q <= rd_ptr_q + PTR_W'(1);
			if (push && !pop) begin
				fill_q <= fill_q + CNT_W'(1);
			end else if (!push && pop) begin
				fill_q <= fill_q - CNT_W'(1);
			end
		end
	end

	// Store beat
	always_ff @(posedge clk) begin
		if (push) mem[wr_ptr_q] <= push_data;
	end

	assign full     = (credit_q == CNT_W'(DEPTH));
	assign empty    = (fill_q == '0);
	assign pop_data = mem[rd_ptr_q];

endmodule

@@ src/pmp_front.sv @@
`timescale 1ns / 1ps

module pmp_front #(
	parameter int COORD_FRAC_BITS = pmp_pkg::COORD_FRAC_BITS_DEF,
	parameter int COEFF_BITS      = pmp_pkg::COEFF_BITS_DEF
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 in_valid,
	input  logic signed [pmp_pkg::POINT_W-1:0]   point_x,
	input  logic signed [pmp_pkg::POINT_W-1:0]   point_y,
	input  logic signed [pmp_pkg::POINT_W-1:0]   point_z,
	input  logic [pmp_pkg::REG_W-1:0]            row0,
	input  logic [pmp_pkg::REG_W-1:0]            row1,
	input  logic [pmp_pkg::REG_W-1:0]            row2,
	output logic                                 out_valid,
	output pmp_pkg::mid_t                        out_data
);

	localparam int PROD_W = COEFF_BITS + pmp_pkg::POINT_W;
	localparam int SUM_W  = pmp_pkg::SUM_W;
	localparam int NUM_W  = pmp_pkg::NUM_W;
	localparam int MAG_W  = pmp_pkg::MAG_W;

	logic [pmp_pkg::REG_W-1:0]            rows [3];
	logic signed [COEFF_BITS-1:0]         coef [3][4];
	logic signed [pmp_pkg::POINT_W-1:0]   pt_s1 [3];
	logic                                 v_s1, v_s2, v_s3;
	logic signed [PROD_W-1:0]             prod_s2 [3][3];
	logic signed [SUM_W-1:0]              cst_s2 [3];
	logic signed [SUM_W-1:0]              sum_s3 [3];
	logic signed [NUM_W-1:0]              num_u, num_v;

	assign rows[0] = row0;
	assign rows[1] = row1;
	assign rows[2] = row2;

	// Pick low bits of each lane as signed coefficients
	always_comb begin
		for (int r = 0; r < 3; r++) begin
			for (int k = 0; k < 4; k++) begin
				coef[r][k] = rows[r][pmp_pkg::LANE_W*k +: COEFF_BITS];
			end
		end
	end

	// Track valid beats down the pipe
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else begin
			v_s1 <= in_valid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
		end
	end

	// Capture point
	always_ff @(posedge clk) begin
		pt_s1[0] <= point_x;
		pt_s1[1] <= point_y;
		pt_s1[2] <= point_z;
	end

	// Multiply each coefficient by its coordinate
	always_ff @(posedge clk) begin
		for (int r = 0; r < 3; r++) begin
			for (int k = 0; k < 3; k++) begin
				prod_s2[r][k] <= coef[r][k] * pt_s1[k];
			end
			cst_s2[r] <= SUM_W'(coef[r][3]) <<< COORD_FRAC_BITS;
		end
	end

	// Add the row terms
	always_ff @(posedge clk) begin
		for (int r = 0; r < 3; r++) begin
			sum_s3[r] <= SUM_W'(prod_s2[r][0]) + SUM_W'(prod_s2[r][1])
				+ SUM_W'(prod_s2[r][2]) + cst_s2[r];
		end
	end

	// Classify: numerators 2u+w, 2v+w folded to magnitudes, divisor 2w
	assign num_u = (NUM_W'(sum_s3[0]) <<< 1) + NUM_W'(sum_s3[2]);
	assign num_v = (NUM_W'(sum_s3[1]) <<< 1) + NUM_W'(sum_s3[2]);

	always_comb begin
		out_data.neg_u = num_u[NUM_W-1];
		out_data.neg_v = num_v[NUM_W-1];
		out_data.mag_u = num_u[NUM_W-1] ? MAG_W'(~num_u) : MAG_W'(num_u);
		out_data.mag_v = num_v[NUM_W-1] ? MAG_W'(~num_v) : MAG_W'(num_v);
		out_data.den   = MAG_W'(sum_s3[2] <<< 1);
		out_data.ok    = (sum_s3[2] > 0);
	end

	assign out_valid = v_s3;

endmodule

@@ src/pmp_back.sv @@
`timescale 1ns / 1ps

module pmp_back (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             in_valid,
	input  pmp_pkg::mid_t                    in_data,
	input  logic [pmp_pkg::FRAME_W-1:0]      frame_width,
	input  logic [pmp_pkg::FRAME_W-1:0]      frame_height,
	output logic                             out_valid,
	output pmp_pkg::res_t                    out_data
);

	localparam int MAG_W = pmp_pkg::MAG_W;
	localparam int QUO_W = pmp_pkg::QUO_W;
	localparam int DIV_W = pmp_pkg::DIV_W;
	localparam int PIX_W = pmp_pkg::PIX_W;

	logic             v_s   [QUO_W+1];
	logic [MAG_W-1:0] rem_u_s [QUO_W+1];
	logic [MAG_W-1:0] rem_v_s [QUO_W+1];
	logic [QUO_W-1:0] q_u_s [QUO_W+1];
	logic [QUO_W-1:0] q_v_s [QUO_W+1];
	logic [MAG_W-1:0] den_s [QUO_W+1];
	logic             neg_u_s [QUO_W+1];
	logic             neg_v_s [QUO_W+1];
	logic             ok_s [QUO_W+1];

	// Load the divider
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s[0] <= 1'b0;
		else         v_s[0] <= in_valid;
	end

	always_ff @(posedge clk) begin
		rem_u_s[0] <= in_data.mag_u;
		rem_v_s[0] <= in_data.mag_v;
		q_u_s[0]   <= '0;
		q_v_s[0]   <= '0;
		den_s[0]   <= in_data.den;
		neg_u_s[0] <= in_data.neg_u;
		neg_v_s[0] <= in_data.neg_v;
		ok_s[0]    <= in_data.ok;
	end

	// One quotient bit per stage, top bit first; the top bit flags overflow
	for (genvar k = 0; k < QUO_W; k++) begin : g_div
		localparam int SH = QUO_W - 1 - k;
		logic [DIV_W-1:0] dsh;
		logic             ge_u, ge_v;

		assign dsh  = DIV_W'(den_s[k]) << SH;
		assign ge_u = DIV_W'(rem_u_s[k]) >= dsh;
		assign ge_v = DIV_W'(rem_v_s[k]) >= dsh;

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) v_s[k+1] <= 1'b0;
			else         v_s[k+1] <= v_s[k];
		end

		always_ff @(posedge clk) begin
			rem_u_s[k+1] <= ge_u ? rem_u_s[k] - dsh[MAG_W-1:0] : rem_u_s[k];
			rem_v_s[k+1] <= ge_v ? rem_v_s[k] - dsh[MAG_W-1:0] : rem_v_s[k];
			q_u_s[k+1]   <= {q_u_s[k][QUO_W-2:0], ge_u};
			q_v_s[k+1]   <= {q_v_s[k][QUO_W-2:0], ge_v};
			den_s[k+1]   <= den_s[k];
			neg_u_s[k+1] <= neg_u_s[k];
			neg_v_s[k+1] <= neg_v_s[k];
			ok_s[k+1]    <= ok_s[k];
		end
	end

	// Unfold sign, saturate, test frame
	logic [QUO_W-1:0]        qu, qv;
	logic signed [PIX_W-1:0] col, row;

	assign qu = q_u_s[QUO_W];
	assign qv = q_v_s[QUO_W];

	always_comb begin
		if (!ok_s[QUO_W]) begin
			col = '0;
		end else if (qu[QUO_W-1]) begin
			col = neg_u_s[QUO_W] ? 16'sh8000 : 16'sh7FFF;
		end else begin
			col = neg_u_s[QUO_W] ? ~{1'b0, qu[QUO_W-2:0]} : {1'b0, qu[QUO_W-2:0]};
		end
		if (!ok_s[QUO_W]) begin
			row = '0;
		end else if (qv[QUO_W-1]) begin
			row = neg_v_s[QUO_W] ? 16'sh8000 : 16'sh7FFF;
		end else begin
			row = neg_v_s[QUO_W] ? ~{1'b0, qv[QUO_W-2:0]} : {1'b0, qv[QUO_W-2:0]};
		end
		out_data.col      = col;
		out_data.row      = row;
		out_data.ok       = ok_s[QUO_W];
		out_data.in_frame = ok_s[QUO_W] && !col[PIX_W-1] && !row[PIX_W-1]
			&& (col < PIX_W'(frame_width)) && (row < PIX_W'(frame_height));
	end

	assign out_valid = v_s[QUO_W];

endmodule

@@ src/pinhole_point_projection.sv @@
// Path: front pipeline, mid queue, divider and output queue, in that order.
// Throughput: one point per cycle, set by the fully pipelined multiply stage and
// the 16-stage bit-per-stage divider; full rises only when results are popped
// slower than points arrive and the queues fill up.
// Reset: asynchronous, active low; clears queues and pipeline valids and loads
// the default camera matrix and a 1500 x 1000 frame.
`timescale 1ns / 1ps

module pinhole_point_projection #(
	parameter int COORD_FRAC_BITS = pmp_pkg::COORD_FRAC_BITS_DEF,
	parameter int COEFF_BITS      = pmp_pkg::COEFF_BITS_DEF
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                push,
	output logic                                full,
	input  logic signed [pmp_pkg::POINT_W-1:0]  point_x,
	input  logic signed [pmp_pkg::POINT_W-1:0]  point_y,
	input  logic signed [pmp_pkg::POINT_W-1:0]  point_z,
	output logic                                empty,
	input  logic                                pop,
	output logic signed [pmp_pkg::PIX_W-1:0]    pixel_col,
	output logic signed [pmp_pkg::PIX_W-1:0]    pixel_row,
	output logic                                depth_ok,
	output logic                                inside_frame,
	input  logic                                psel,
	input  logic                                penable,
	input  logic                                pwrite,
	input  logic [pmp_pkg::ADDR_W-1:0]          paddr,
	input  logic [pmp_pkg::REG_W-1:0]           pwdata,
	output logic [pmp_pkg::REG_W-1:0]           prdata,
	output logic                                pready
);

	logic [pmp_pkg::REG_W-1:0]   row0_q, row1_q, row2_q;
	logic [pmp_pkg::FRAME_W-1:0] width_q, height_q;
	logic [2:0]                  reg_idx;
	logic                        wr_en;

	assign pready  = 1'b1;
	assign reg_idx = paddr[5:3];
	assign wr_en   = psel && penable && pwrite && pready;

	// Write configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row0_q   <= pmp_pkg::ROW0_RST;
			row1_q   <= pmp_pkg::ROW1_RST;
			row2_q   <= pmp_pkg::ROW2_RST;
			width_q  <= pmp_pkg::WIDTH_RST;
			height_q <= pmp_pkg::HEIGHT_RST;
		end else if (wr_en) begin
			case (reg_idx)
				pmp_pkg::REG_ROW0:   row0_q   <= pwdata;
				pmp_pkg::REG_ROW1:   row1_q   <= pwdata;
				pmp_pkg::REG_ROW2:   row2_q   <= pwdata;
				pmp_pkg::REG_WIDTH:  width_q  <= pwdata[pmp_pkg::FRAME_W-1:0];
				pmp_pkg::REG_HEIGHT: height_q <= pwdata[pmp_pkg::FRAME_W-1:0];
				default: ;
			endcase
		end
	end

	// Read back
	always_comb begin
		case (reg_idx)
			pmp_pkg::REG_ROW0:   prdata = row0_q;
			pmp_pkg::REG_ROW1:   prdata = row1_q;
			pmp_pkg::REG_ROW2:   prdata = row2_q;
			pmp_pkg::REG_WIDTH:  prdata = pmp_pkg::REG_W'(width_q);
			pmp_pkg::REG_HEIGHT: prdata = pmp_pkg::REG_W'(height_q);
			default:             prdata = '0;
		endcase
	end

	logic          in_acc;
	logic          front_v;
	pmp_pkg::mid_t front_d;
	logic          midq_empty;
	pmp_pkg::mid_t midq_d;
	logic          back_acc;
	logic          back_v;
	pmp_pkg::res_t back_d;
	logic          outq_full;
	pmp_pkg::res_t outq_d;

	assign in_acc   = push && !full;
	assign back_acc = !midq_empty && !outq_full;

	pmp_front #(
		.COORD_FRAC_BITS (COORD_FRAC_BITS),
		.COEFF_BITS      (COEFF_BITS)
	) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_acc),
		.point_x   (point_x),
		.point_y   (point_y),
		.point_z   (point_z),
		.row0      (row0_q),
		.row1      (row1_q),
		.row2      (row2_q),
		.out_valid (front_v),
		.out_data  (front_d)
	);

	pmp_fifo #(
		.W     ($bits(pmp_pkg::mid_t)),
		.DEPTH (pmp_pkg::MIDQ_DEPTH)
	) u_midq (
		.clk       (clk),
		.arst_n    (arst_n),
		.reserve   (in_acc),
		.push      (front_v),
		.push_data (front_d),
		.pop       (back_acc),
		.full      (full),
		.empty     (midq_empty),
		.pop_data  (midq_d)
	);

	pmp_back u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (back_acc),
		.in_data      (midq_d),
		.frame_width  (width_q),
		.frame_height (height_q),
		.out_valid    (back_v),
		.out_data     (back_d)
	);

	pmp_fifo #(
		.W     ($bits(pmp_pkg::res_t)),
		.DEPTH (pmp_pkg::OUTQ_DEPTH)
	) u_outq (
		.clk       (clk),
		.arst_n    (arst_n),
		.reserve   (back_acc),
		.push      (back_v),
		.push_data (back_d),
		.pop       (pop && !empty),
		.full      (outq_full),
		.empty     (empty),
		.pop_data  (outq_d)
	);

	assign pixel_col    = outq_d.col;
	assign pixel_row    = outq_d.row;
	assign depth_ok     = outq_d.ok;
	assign inside_frame = outq_d.in_frame;

	// Invalid depth gives a zero pixel outside the frame
	a_bad_depth: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && !depth_ok) |-> (pixel_col == '0 && pixel_row == '0 && !inside_frame))
		else $error("invalid depth result not cleared");

	// An inside pixel lies within the configured frame
	a_inside: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && inside_frame) |-> (!pixel_col[pmp_pkg::PIX_W-1]
			&& !pixel_row[pmp_pkg::PIX_W-1]
			&& pixel_col < pmp_pkg::PIX_W'(width_q)
			&& pixel_row < pmp_pkg::PIX_W'(height_q)))
		else $error("inside flag set for pixel outside frame");

	// Back end only takes an item when the mid queue holds one and the output queue is not full
	a_back_take: assert property (@(posedge clk) disable iff (!arst_n)
		back_acc |-> !midq_empty && !outq_full)
		else $error("back end took from empty queue");

endmodule
